/* design/rls_pkg.sv */
// Shared types, constants and helper functions for the RLS ARX estimator.
`default_nettype none
package rls_pkg;

  localparam int unsigned CovWidthDefault = 48;
  localparam int unsigned LamWidth        = 25;
  localparam int unsigned ScaleWidth      = 16;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned AccWidth        = 64;
  localparam int unsigned CfgIdxWidth     = 8;
  localparam logic [LamWidth-1:0] LamReset   = 25'd16760438;
  localparam logic [ScaleWidth-1:0] ScaleReset = 16'd1000;
  localparam logic [LamWidth-1:0] LamMin     = 25'd8388608;
  localparam logic [LamWidth-1:0] LamMax     = 25'd16777216;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_LAMBDA = 8'd0,
    REG_SCALE  = 8'd1
  } cfg_reg_t;

  // Controller states. Each phase walks its loop through the shared units.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_YHAT,
    ST_VW,
    ST_DEN,
    ST_GAIN,
    ST_COV_MUL,
    ST_COV_DIV,
    ST_THETA,
    ST_OUT
  } state_t;

  // Multiplier operand selector
  typedef enum logic [2:0] {
    MSEL_YHAT,
    MSEL_V,
    MSEL_W,
    MSEL_DEN,
    MSEL_COV,
    MSEL_THETA
  } msel_t;

  typedef struct packed {
    logic       load;      // latch input beat, shift regressor
    logic       init;      // first beat: clear state, load covariance
    logic       mul_go;    // start one multiply
    msel_t      msel;
    logic       div_go;    // start one divide
    logic       div_cov;   // divide is covariance / lambda (else gain)
    logic [3:0] idx;       // element index (i*4+j)
    logic       finish_err;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

  function automatic logic signed [AccWidth-1:0] sadd64(
      input logic signed [AccWidth-1:0] a, input logic signed [AccWidth-1:0] b);
    logic signed [AccWidth:0] s;
    s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1])
      return s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    return s[AccWidth-1:0];
  endfunction

  function automatic logic signed [AccWidth-1:0] ssub64(
      input logic signed [AccWidth-1:0] a, input logic signed [AccWidth-1:0] b);
    logic signed [AccWidth:0] s;
    s = {a[AccWidth-1], a} - {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1])
      return s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    return s[AccWidth-1:0];
  endfunction

  function automatic logic signed [DataWidth-1:0] sat32(input logic signed [AccWidth-1:0] x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[DataWidth-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/rls_chan_if.sv */
// Valid/ready channel interfaces for input, result and configuration beats.
`default_nettype none
interface rls_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  new_position;
  logic signed [31:0]  drive_input;
  modport source (output valid, new_position, drive_input, input ready);
  modport sink   (input valid, new_position, drive_input, output ready);
endinterface

interface rls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coeff_a1;
  logic signed [31:0] coeff_a2;
  logic signed [31:0] coeff_b1;
  logic signed [31:0] coeff_b2;
  logic signed [31:0] prediction_error;
  modport source (output valid, coeff_a1, coeff_a2, coeff_b1, coeff_b2,
                  prediction_error, input ready);
  modport sink   (input valid, coeff_a1, coeff_a2, coeff_b1, coeff_b2,
                  prediction_error, output ready);
endinterface

interface rls_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/rls_mul.sv */
// Sequential 64x64 signed multiply with rounding shift, four 32x32 partials.
`default_nettype none
module rls_mul
  import rls_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic signed [AccWidth-1:0] a,
  input  wire logic signed [AccWidth-1:0] b,
  input  wire logic [5:0]                 sh,
  output logic                            done,
  output logic signed [AccWidth-1:0]      result
);
  logic [2:0]   step;
  logic         busy;
  logic         neg;
  logic [63:0]  ua, ub;
  logic [127:0] acc;
  logic [63:0]  part;
  logic [127:0] part_sh;
  logic [127:0] rnd;
  logic [127:0] shifted;

  // one 32x32 partial product per step, accumulated at its weight
  always_comb begin
    unique case (step[1:0])
      2'd0: part = ua[31:0] * ub[31:0];
      2'd1: part = ua[31:0] * ub[63:32];
      2'd2: part = ua[63:32] * ub[31:0];
      default: part = ua[63:32] * ub[63:32];
    endcase
    unique case (step[1:0])
      2'd0: part_sh = {64'd0, part};
      2'd1, 2'd2: part_sh = {32'd0, part, 32'd0};
      default: part_sh = {part, 64'd0};
    endcase
    rnd = acc + (128'd1 << (sh - 6'd1));
    shifted = rnd >> sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= '0;
        neg  <= (a[63] != b[63]);
        ua   <= a[63] ? 64'(-a) : 64'(a);
        ub   <= b[63] ? 64'(-b) : 64'(b);
      end else if (busy) begin
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            if (shifted[127:63] != '0) result <= {1'b1, 63'd0};
            else result <= -$signed(shifted[63:0]);
          end else begin
            if (shifted[127:63] != '0) result <= {1'b0, {63{1'b1}}};
            else result <= $signed(shifted[63:0]);
          end
        end else begin
          acc  <= acc + part_sh;
          step <= step + 3'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/rls_div.sv */
// Restoring divider: (num << sh) / den, one quotient bit a cycle, saturated.
`default_nettype none
module rls_div
  import rls_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic signed [AccWidth-1:0] num,
  input  wire logic signed [AccWidth-1:0] den,
  input  wire logic [5:0]                 sh,
  output logic                            done,
  output logic signed [AccWidth-1:0]      result
);
  logic         busy;
  logic [6:0]   cnt;
  logic         neg;
  logic         dzero;
  logic [127:0] n;
  logic [127:0] q;
  logic [63:0]  d;
  logic [64:0]  rem;
  logic [64:0]  trial;
  logic         qbit;

  always_comb begin
    trial = {rem[63:0], n[127]};
    qbit  = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        cnt   <= '0;
        neg   <= (num[63] != den[63]);
        dzero <= (den == '0);
        d     <= den[63] ? 64'(-den) : 64'(den);
        n     <= {64'd0, (num[63] ? 64'(-num) : 64'(num))} << sh;
        q     <= '0;
        rem   <= '0;
      end else if (busy) begin
        if (cnt == 7'd127 + 7'd1 - 7'd1 && cnt[6:0] == 7'd127) begin
          busy <= 1'b0;
        end
        n   <= n << 1;
        q   <= {q[126:0], qbit};
        rem <= qbit ? trial - {1'b0, d} : trial;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          done <= 1'b1;
          if (dzero) result <= '0;
          else if (neg) begin
            if ({q[126:0], qbit} > {65'd0, 63'd0} + (128'd1 << 63)) result <= {1'b1, 63'd0};
            else result <= -$signed(64'({q[126:0], qbit}));
          end else begin
            if ({q[126:0], qbit} > 128'h7FFF_FFFF_FFFF_FFFF) result <= {1'b0, {63{1'b1}}};
            else result <= $signed(64'({q[126:0], qbit}));
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/rls_datapath.sv */
// RLS datapath: state registers, operand selection, shared multiplier and divider.
`default_nettype none
module rls_datapath
  import rls_pkg::*;
#(
  parameter int unsigned COV_WIDTH = CovWidthDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cmd_t                        cmd,
  output sts_t                             sts,
  input  wire logic signed [DataWidth-1:0] y_in,
  input  wire logic signed [DataWidth-1:0] u_in,
  input  wire logic [LamWidth-1:0]         lambda_reg,
  input  wire logic [ScaleWidth-1:0]       scale_reg,
  output logic signed [DataWidth-1:0]      theta_out [4],
  output logic signed [DataWidth-1:0]      err_out
);
  logic signed [DataWidth-1:0] phi [4];
  logic signed [DataWidth-1:0] theta [4];
  logic signed [DataWidth-1:0] prev_y, prev_u, y_cur;
  logic signed [COV_WIDTH-1:0] cov [16];
  logic signed [AccWidth-1:0]  v [4], w [4], g [4];
  logic signed [AccWidth-1:0]  acc, den, tmp;
  logic signed [DataWidth-1:0] err;
  logic [LamWidth-1:0]         lam;
  logic [1:0] ii, jj;
  logic signed [AccWidth-1:0] ma, mb, mres, dnum, dden, dres;
  logic [5:0] msh, dsh;
  logic mdone, ddone;
  logic signed [AccWidth-1:0] cov_init;

  assign ii = cmd.idx[3:2];
  assign jj = cmd.idx[1:0];
  assign lam = (lambda_reg < LamMin) ? LamMin : ((lambda_reg > LamMax) ? LamMax : lambda_reg);

  always_comb begin
    ma = '0; mb = '0; msh = 6'd16;
    unique case (cmd.msel)
      MSEL_YHAT:  begin ma = AccWidth'(phi[jj]); mb = AccWidth'(theta[jj]); msh = 6'd24; end
      MSEL_V:     begin ma = AccWidth'(cov[cmd.idx]); mb = AccWidth'(phi[jj]); end
      MSEL_W:     begin ma = AccWidth'(phi[jj]); mb = AccWidth'(cov[{jj, ii}]); end
      MSEL_DEN:   begin ma = AccWidth'(phi[jj]); mb = v[jj]; msh = 6'd8; end
      MSEL_COV:   begin ma = g[ii]; mb = w[jj]; msh = 6'd32; end
      default:    begin ma = AccWidth'(err); mb = g[jj]; msh = 6'd24; end
    endcase
    if (cmd.div_cov) begin
      dnum = tmp; dden = AccWidth'($signed({1'b0, lam})); dsh = 6'd24;
    end else begin
      dnum = v[jj]; dden = den; dsh = 6'd40;
    end
    cov_init = $signed(AccWidth'(scale_reg) << 16);
  end

  rls_mul u_mul (.clk, .rst, .go(cmd.mul_go), .a(ma), .b(mb), .sh(msh),
                 .done(mdone), .result(mres));
  rls_div u_div (.clk, .rst, .go(cmd.div_go), .num(dnum), .den(dden), .sh(dsh),
                 .done(ddone), .result(dres));

  assign sts.mul_done = mdone;
  assign sts.div_done = ddone;

  function automatic logic signed [COV_WIDTH-1:0] satc(input logic signed [AccWidth-1:0] x);
    logic signed [AccWidth-1:0] hi;
    hi = (COV_WIDTH >= AccWidth) ? {1'b0, {(AccWidth-1){1'b1}}}
                                  : ((64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1);
    if (x > hi) return hi[COV_WIDTH-1:0];
    if (x < -hi - 64'sd1) return COV_WIDTH'(-hi - 64'sd1);
    return x[COV_WIDTH-1:0];
  endfunction

  // lagged samples survive the first-beat clear
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_y <= '0;
      prev_u <= '0;
    end else if (cmd.load) begin
      prev_y <= y_in;
      prev_u <= u_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int k = 0; k < 4; k++) begin
        phi[k] <= '0; theta[k] <= '0;
      end
      for (int k = 0; k < 16; k++) cov[k] <= (k % 5 == 0) ? satc(cov_init) : '0;
    end
    if (cmd.load) begin
      phi[3] <= phi[2];
      phi[1] <= phi[0];
      phi[0] <= (prev_y == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -prev_y;
      phi[2] <= prev_u;
      y_cur  <= y_in;
      acc    <= '0;
      den    <= AccWidth'($signed({1'b0, lam}));
      for (int k = 0; k < 4; k++) begin v[k] <= '0; w[k] <= '0; end
    end
    if (mdone) begin
      unique case (cmd.msel)
        MSEL_YHAT: acc <= sadd64(acc, mres);
        MSEL_V:    v[ii] <= sadd64(v[ii], mres);
        MSEL_W:    w[ii] <= sadd64(w[ii], mres);
        MSEL_DEN:  den <= sadd64(den, mres);
        MSEL_COV:  tmp <= ssub64(AccWidth'(cov[cmd.idx]), mres);
        default:   theta[jj] <= sat32(sadd64(AccWidth'(theta[jj]), mres));
      endcase
    end
    if (cmd.finish_err) err <= sat32(ssub64(AccWidth'(y_cur), acc));
    if (ddone) begin
      if (cmd.div_cov) cov[cmd.idx] <= satc(dres);
      else g[jj] <= (den > 0) ? dres : '0;
    end
    if (cmd.out_load) begin
      for (int k = 0; k < 4; k++) theta_out[k] <= theta[k];
      err_out <= err;
    end
  end
endmodule
`default_nettype wire

/* design/rls_ctrl.sv */
// RLS sequencer: walks the update phases, issuing one unit operation at a time.
`default_nettype none
module rls_ctrl
  import rls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      out_set
);
  state_t     state, state_next;
  logic       started;
  logic [3:0] idx, idx_next;
  logic       issued, issued_next;
  logic       opdone;

  assign opdone = sts.mul_done | sts.div_done;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    issued_next = issued;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = started ? ST_YHAT : ST_INIT;
      ST_INIT: state_next = ST_YHAT;
      ST_YHAT, ST_VW, ST_DEN, ST_GAIN, ST_COV_MUL, ST_COV_DIV, ST_THETA: begin
        if (!issued) issued_next = 1'b1;
        else if (opdone) begin
          issued_next = 1'b0;
          priority case (state)
            ST_VW: begin
              // advance over all 16 elements; the pass flag picks v or w
              idx_next = idx + 4'd1;
            end
            default: ;
          endcase
          priority case (state)
            ST_YHAT:  if (idx[1:0] == 2'd3) begin idx_next = '0; state_next = ST_VW; end
                      else idx_next = idx + 4'd1;
            ST_VW:    ;
            ST_DEN:   if (idx[1:0] == 2'd3) begin idx_next = '0; state_next = ST_GAIN; end
                      else idx_next = idx + 4'd1;
            ST_GAIN:  if (idx[1:0] == 2'd3) begin idx_next = '0; state_next = ST_COV_MUL; end
                      else idx_next = idx + 4'd1;
            ST_COV_MUL: state_next = ST_COV_DIV;
            ST_COV_DIV: if (idx == 4'd15) begin idx_next = '0; state_next = ST_THETA; end
                        else begin idx_next = idx + 4'd1; state_next = ST_COV_MUL; end
            default:  if (idx[1:0] == 2'd3) begin idx_next = '0; state_next = ST_OUT; end
                      else idx_next = idx + 4'd1;
          endcase
        end
      end
      default: if (out_free) state_next = ST_IDLE;
    endcase
  end

  // ST_VW runs two passes over idx: first all v, then all w
  logic pass_w, pass_w_next;
  always_comb begin
    pass_w_next = pass_w;
    if (state == ST_VW && issued && opdone) begin
      if (idx == 4'd15) begin
        pass_w_next = ~pass_w;
      end
    end
  end

  state_t st_fix;
  always_comb begin
    st_fix = state_next;
    if (state == ST_VW && issued && opdone && idx == 4'd15 && pass_w) st_fix = ST_DEN;
  end

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.msel = MSEL_YHAT;
    cmd.load = (state == ST_IDLE) && in_fire;
    cmd.init = (state == ST_INIT);
    unique case (state)
      ST_YHAT:    begin cmd.msel = MSEL_YHAT; cmd.mul_go = !issued; end
      ST_VW:      begin cmd.msel = pass_w ? MSEL_W : MSEL_V; cmd.mul_go = !issued; end
      ST_DEN:     begin cmd.msel = MSEL_DEN; cmd.mul_go = !issued; end
      ST_GAIN:    begin cmd.div_go = !issued; end
      ST_COV_MUL: begin cmd.msel = MSEL_COV; cmd.mul_go = !issued; end
      ST_COV_DIV: begin cmd.msel = MSEL_COV; cmd.div_cov = 1'b1; cmd.div_go = !issued; end
      ST_THETA:   begin cmd.msel = MSEL_THETA; cmd.mul_go = !issued; end
      default: ;
    endcase
    cmd.finish_err = (state == ST_VW) && !issued && idx == '0 && !pass_w;
    cmd.out_load = (state == ST_OUT) && out_free;
  end

  assign busy    = (state != ST_IDLE);
  assign out_set = cmd.out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      issued  <= 1'b0;
      started <= 1'b0;
      pass_w  <= 1'b0;
    end else begin
      state  <= st_fix;
      idx    <= idx_next;
      issued <= issued_next;
      pass_w <= pass_w_next;
      if (state == ST_INIT) started <= 1'b1;
    end
  end
endmodule
`default_nettype wire

/* design/rls_arx_parameter_estimator.sv */
// Top level of the four-parameter RLS ARX estimator.
// Usage:
//   in_ch  : one beat carries new_position y(k) and drive_input u(k), Q16.16.
//   out_ch : one beat per input beat with the four Q8.24 estimates and the
//            saturated a priori prediction error.
//   cfg_ch : register index 0 is lambda (Q1.24), index 1 the initial
//            covariance scale; write only while the block is idle.
// Work per item: 20 divides (four gains and the 16 covariance entries) on
//   the shared divider and 60 multiplies on the shared multiplier, issued
//   one at a time.
// Throughput: one item at a time; the next beat is taken once the previous
//   result has moved into the output register.
// Reset clears the sequencer, the first-item flag and the lagged samples;
//   registers return to lambda 16760438 and scale 1000. The first beat after
//   reset loads the covariance with scale times the identity.
// A stalled receiver holds the result register; the block waits in its
//   output state until the register is free, then drops back to idle.
`default_nettype none
module rls_arx_parameter_estimator
  import rls_pkg::*;
#(
  parameter int unsigned COV_WIDTH = CovWidthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  rls_in_if.sink    in_ch,
  rls_out_if.source out_ch,
  rls_cfg_if.sink   cfg_ch
);
  logic [LamWidth-1:0]   lambda_reg;
  logic [ScaleWidth-1:0] scale_reg;
  cmd_t cmd;
  sts_t sts;
  logic busy, out_set, in_fire, out_free;
  logic out_valid;
  logic signed [DataWidth-1:0] theta_out [4];
  logic signed [DataWidth-1:0] err_out;

  assign cfg_ch.ready = 1'b1;
  // hold register writes to the named indexes; others are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_reg <= LamReset;
      scale_reg  <= ScaleReset;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_LAMBDA) lambda_reg <= cfg_ch.data[LamWidth-1:0];
      if (cfg_ch.index == REG_SCALE)  scale_reg  <= cfg_ch.data[ScaleWidth-1:0];
    end
  end

  assign in_ch.ready = !busy;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  rls_ctrl u_ctrl (.clk, .rst, .in_fire, .out_free, .sts, .cmd, .busy, .out_set);

  rls_datapath #(.COV_WIDTH(COV_WIDTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .y_in(in_ch.new_position), .u_in(in_ch.drive_input),
    .lambda_reg, .scale_reg, .theta_out, .err_out
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.coeff_a1 = theta_out[0];
  assign out_ch.coeff_a2 = theta_out[1];
  assign out_ch.coeff_b1 = theta_out[2];
  assign out_ch.coeff_b2 = theta_out[3];
  assign out_ch.prediction_error = err_out;

  // no input beat taken while an item is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("input taken while busy");
  // a result beat is only raised from the output state
  a_out_from_set: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(out_set)) else $error("result without update");
  // multiplier and divider never finish together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(sts.mul_done && sts.div_done)) else $error("both units done");
endmodule
`default_nettype wire
